/* src/nmea_talker_rewrite_checksum_top_defines.svh */
// Assertion macros shared by the talker rewrite block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef NMEA_TALKER_REWRITE_CHECKSUM_TOP_DEFINES_SVH
`define NMEA_TALKER_REWRITE_CHECKSUM_TOP_DEFINES_SVH

// Implication checked on the next clock edge.
`define NTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked on the same clock edge.
`define NTR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/nmea_trw_pkg.sv */
// Package for the NMEA talker rewrite block: character codes, phase codes,
// state and step types, and the hex digit function. Depends on nothing.
`timescale 1ns / 1ps

package nmea_trw_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TALK1 = 3'd1;
  localparam logic [2:0] PH_TALK2 = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_CK1   = 3'd4;
  localparam logic [2:0] PH_CK2   = 3'd5;

  localparam logic REG_SRC_MASK = 1'b0;
  localparam logic REG_HEX_UPPER = 1'b1;

  localparam logic [2:0] SRC_MASK_RST = 3'd7;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] held_char;
    logic       rewriting;
    logic [7:0] running_xor;
  } trw_state_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } trw_words_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + {4'h0, nib};
    end else begin
      hex_digit = base + {4'h0, nib} - 8'd10;
    end
  endfunction

endpackage

/* src/nmea_talker_rewrite_checksum_top.sv */
// A byte in the input register is processed when the result register is free
// or the byte yields no word; processing loads its first word onto the output.
// Throughput: one input byte per cycle while each byte yields at most one word
// and out_ready is high; a two-word byte holds the result until both are taken.
// Reset (synchronous, rst_n low) empties both stages, returns the parser to
// idle with a cleared checksum, and restores the register defaults.
`timescale 1ns / 1ps
`include "nmea_talker_rewrite_checksum_top_defines.svh"

module nmea_talker_rewrite_checksum_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]               src_mask_r;
  logic                     hex_upper_r;
  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  nmea_trw_pkg::trw_state_t st_r;
  nmea_trw_pkg::trw_state_t st_nxt;
  nmea_trw_pkg::trw_words_t step_words;
  logic [1:0]               res_cnt_r;
  logic [7:0]               res_b0_r;
  logic [7:0]               res_b1_r;
  logic                     out_fire;
  logic                     res_free;
  logic                     advance;
  logic                     cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    prdata = 32'h0;
    unique case (paddr[2])
      nmea_trw_pkg::REG_SRC_MASK:  prdata = {29'h0, src_mask_r};
      nmea_trw_pkg::REG_HEX_UPPER: prdata = {31'h0, hex_upper_r};
      default:                     prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_mask_r <= nmea_trw_pkg::SRC_MASK_RST;
      hex_upper_r <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == nmea_trw_pkg::REG_SRC_MASK) begin
        src_mask_r <= pwdata[2:0];
      end else begin
        hex_upper_r <= pwdata[0];
      end
    end
  end

  nmea_trw_step u_step (
    .cur       (st_r),
    .data      (in_byte_r),
    .src_mask  (src_mask_r),
    .hex_upper (hex_upper_r),
    .nxt       (st_nxt),
    .words     (step_words)
  );

  assign out_valid = (res_cnt_r != 2'd0);
  assign out_byte = res_b0_r;
  assign out_run_last = (res_cnt_r == 2'd1);
  assign out_fire = out_valid & out_ready;
  assign res_free = (res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && out_ready);
  assign advance = in_valid_r && (res_free || (step_words.count == 2'd0));
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
    end else if (advance && (step_words.count != 2'd0)) begin
      res_cnt_r <= step_words.count;
    end else if (out_fire) begin
      res_cnt_r <= res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (step_words.count != 2'd0)) begin
      res_b0_r <= step_words.byte0;
      res_b1_r <= step_words.byte1;
    end else if (out_fire) begin
      res_b0_r <= res_b1_r;
    end
  end

  `NTR_ASSERT_NEXT(a_second_word, out_fire && (res_cnt_r == 2'd2),
    (res_cnt_r == 2'd1) && (out_byte == $past(res_b1_r)), "second word lost after shift")
  `NTR_ASSERT_NEXT(a_step_loads, advance && (step_words.count != 2'd0),
    out_valid, "processed byte produced no word")
  `NTR_ASSERT_NEXT(a_input_holds, in_valid_r && !advance,
    in_valid_r && $stable(in_byte_r), "stalled input stage changed")
  `NTR_ASSERT_SAME(a_no_overwrite, advance && (step_words.count != 2'd0),
    (res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && out_fire), "result overwritten")

endmodule

/* src/nmea_trw_step.sv */
// Next-state and result logic for one stream byte of the talker rewrite.
// Depends on nmea_trw_pkg for codes, types and the hex digit function.
`timescale 1ns / 1ps

module nmea_trw_step (
  input  nmea_trw_pkg::trw_state_t cur,
  input  logic [7:0]               data,
  input  logic [2:0]               src_mask,
  input  logic                     hex_upper,
  output nmea_trw_pkg::trw_state_t nxt,
  output nmea_trw_pkg::trw_words_t words
);

  logic       rw;
  logic [7:0] c0;
  logic [7:0] c1;

  always_comb begin
    rw = ((cur.held_char == nmea_trw_pkg::CH_G) && (data == nmea_trw_pkg::CH_L) && src_mask[0])
      || ((cur.held_char == nmea_trw_pkg::CH_B) && (data == nmea_trw_pkg::CH_D) && src_mask[1])
      || ((cur.held_char == nmea_trw_pkg::CH_G) && (data == nmea_trw_pkg::CH_N) && src_mask[2]);
    c0 = rw ? nmea_trw_pkg::CH_G : cur.held_char;
    c1 = rw ? nmea_trw_pkg::CH_P : data;
  end

  always_comb begin
    nxt = cur;
    words.count = 2'd1;
    words.byte0 = data;
    words.byte1 = data;
    if (data == nmea_trw_pkg::CH_DOLLAR) begin
      if (cur.phase == nmea_trw_pkg::PH_TALK2) begin
        words.count = 2'd2;
        words.byte0 = cur.held_char;
      end
      nxt.phase = nmea_trw_pkg::PH_TALK1;
      nxt.running_xor = 8'h00;
      nxt.rewriting = 1'b0;
      nxt.held_char = 8'h00;
    end else begin
      unique case (cur.phase)
        nmea_trw_pkg::PH_TALK1: begin
          if (data == nmea_trw_pkg::CH_STAR) begin
            nxt.phase = nmea_trw_pkg::PH_CK1;
          end else begin
            words.count = 2'd0;
            nxt.held_char = data;
            nxt.phase = nmea_trw_pkg::PH_TALK2;
          end
        end
        nmea_trw_pkg::PH_TALK2: begin
          words.count = 2'd2;
          if (data == nmea_trw_pkg::CH_STAR) begin
            words.byte0 = cur.held_char;
            nxt.running_xor = cur.running_xor ^ cur.held_char;
            nxt.phase = nmea_trw_pkg::PH_CK1;
          end else begin
            words.byte0 = c0;
            words.byte1 = c1;
            nxt.running_xor = cur.running_xor ^ c0 ^ c1;
            nxt.rewriting = rw;
            nxt.phase = nmea_trw_pkg::PH_BODY;
          end
        end
        nmea_trw_pkg::PH_BODY: begin
          if (data == nmea_trw_pkg::CH_STAR) begin
            nxt.phase = nmea_trw_pkg::PH_CK1;
          end else begin
            nxt.running_xor = cur.running_xor ^ data;
          end
        end
        nmea_trw_pkg::PH_CK1: begin
          if (cur.rewriting) begin
            words.byte0 = nmea_trw_pkg::hex_digit(cur.running_xor[7:4], hex_upper);
          end
          nxt.phase = nmea_trw_pkg::PH_CK2;
        end
        nmea_trw_pkg::PH_CK2: begin
          if (cur.rewriting) begin
            words.byte0 = nmea_trw_pkg::hex_digit(cur.running_xor[3:0], hex_upper);
          end
          nxt.phase = nmea_trw_pkg::PH_IDLE;
        end
        default: begin
          nxt.phase = nmea_trw_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/nmea_talker_rewrite_checksum_top_tb.sv */
// Self-checking testbench for nmea_talker_rewrite_checksum_top: random NMEA sentences,
// noise and broken sentences under several register settings and idling patterns.
// Depends on nmea_trw_pkg and the block itself.
`timescale 1ns / 1ps

module nmea_talker_rewrite_checksum_top_tb;

  class talker_scoreboard;
    logic [2:0] src_mask;
    logic       hex_upper;
    logic [2:0] phase;
    logic [7:0] held;
    logic       rewriting;
    logic [7:0] csum;
    logic [7:0] exp_byte_q[$];
    logic       exp_last_q[$];
    int         errors;

    function new();
      src_mask  = nmea_trw_pkg::SRC_MASK_RST;
      hex_upper = 1'b0;
      phase     = nmea_trw_pkg::PH_IDLE;
      held      = 8'h00;
      rewriting = 1'b0;
      csum      = 8'h00;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      case (idx)
        nmea_trw_pkg::REG_SRC_MASK:  src_mask = value[2:0];
        nmea_trw_pkg::REG_HEX_UPPER: hex_upper = value[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      string lut;
      lut = hex_upper ? "0123456789ABCDEF" : "0123456789abcdef";
      return lut[nib];
    endfunction

    function int pending();
      return exp_byte_q.size();
    endfunction

    function void note_input(logic [7:0] b);
      logic [7:0] w[2];
      int         n;
      logic       rw;
      n = 0;
      if (b == nmea_trw_pkg::CH_DOLLAR) begin
        if (phase == nmea_trw_pkg::PH_TALK2) begin
          w[n] = held;
          n++;
        end
        w[n] = b;
        n++;
        phase     = nmea_trw_pkg::PH_TALK1;
        csum      = 8'h00;
        rewriting = 1'b0;
        held      = 8'h00;
      end else begin
        case (phase)
          nmea_trw_pkg::PH_TALK1: begin
            if (b == nmea_trw_pkg::CH_STAR) begin
              w[n] = b;
              n++;
              phase = nmea_trw_pkg::PH_CK1;
            end else begin
              held  = b;
              phase = nmea_trw_pkg::PH_TALK2;
            end
          end
          nmea_trw_pkg::PH_TALK2: begin
            if (b == nmea_trw_pkg::CH_STAR) begin
              w[0] = held;
              w[1] = b;
              n = 2;
              csum ^= held;
              phase = nmea_trw_pkg::PH_CK1;
            end else begin
              rw = (held == nmea_trw_pkg::CH_G && b == nmea_trw_pkg::CH_L && src_mask[0]) ||
                   (held == nmea_trw_pkg::CH_B && b == nmea_trw_pkg::CH_D && src_mask[1]) ||
                   (held == nmea_trw_pkg::CH_G && b == nmea_trw_pkg::CH_N && src_mask[2]);
              w[0] = rw ? nmea_trw_pkg::CH_G : held;
              w[1] = rw ? nmea_trw_pkg::CH_P : b;
              n = 2;
              csum ^= w[0] ^ w[1];
              rewriting = rw;
              phase = nmea_trw_pkg::PH_BODY;
            end
          end
          nmea_trw_pkg::PH_BODY: begin
            w[n] = b;
            n++;
            if (b == nmea_trw_pkg::CH_STAR) phase = nmea_trw_pkg::PH_CK1;
            else csum ^= b;
          end
          nmea_trw_pkg::PH_CK1: begin
            w[n] = rewriting ? hex_char(csum[7:4]) : b;
            n++;
            phase = nmea_trw_pkg::PH_CK2;
          end
          nmea_trw_pkg::PH_CK2: begin
            w[n] = rewriting ? hex_char(csum[3:0]) : b;
            n++;
            phase = nmea_trw_pkg::PH_IDLE;
          end
          default: begin
            w[n] = b;
            n++;
            phase = nmea_trw_pkg::PH_IDLE;
          end
        endcase
      end
      for (int i = 0; i < n; i++) begin
        exp_byte_q.push_back(w[i]);
        exp_last_q.push_back(i == n - 1);
      end
    endfunction

    function void check_word(logic [7:0] b, logic last);
      logic [7:0] eb;
      logic       el;
      if (exp_byte_q.size() == 0) begin
        $error("unexpected word: out_byte %h out_run_last %b", b, last);
        errors++;
        return;
      end
      eb = exp_byte_q.pop_front();
      el = exp_last_q.pop_front();
      if (b !== eb) begin
        $error("out_byte expected %h actual %h", eb, b);
        errors++;
      end
      if (last !== el) begin
        $error("out_run_last expected %b actual %b", el, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  talker_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int bytes_sent;

  nmea_talker_rewrite_checksum_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_run_last(out_run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL nmea_talker_rewrite_checksum_top");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_byte, out_run_last);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h20, 8'h7E));
    while (c == nmea_trw_pkg::CH_DOLLAR || c == nmea_trw_pkg::CH_STAR);
    return c;
  endfunction

  task automatic send_sentence();
    logic [7:0] s[$];
    string      hexset;
    int         len;
    int         cut;
    hexset = "0123456789ABCDEFabcdef";
    s.push_back(nmea_trw_pkg::CH_DOLLAR);
    case ($urandom_range(0, 5))
      0: begin s.push_back(nmea_trw_pkg::CH_G); s.push_back(nmea_trw_pkg::CH_L); end
      1: begin s.push_back(nmea_trw_pkg::CH_B); s.push_back(nmea_trw_pkg::CH_D); end
      2: begin s.push_back(nmea_trw_pkg::CH_G); s.push_back(nmea_trw_pkg::CH_N); end
      3: begin s.push_back(nmea_trw_pkg::CH_G); s.push_back(nmea_trw_pkg::CH_P); end
      4: begin
        s.push_back(nmea_trw_pkg::CH_G);
        s.push_back(8'($urandom_range(8'h41, 8'h5A)));
      end
      default: begin
        s.push_back(8'($urandom_range(0, 255)));
        s.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) s.push_back(body_char());
    s.push_back(nmea_trw_pkg::CH_STAR);
    s.push_back(hexset[$urandom_range(0, 21)]);
    s.push_back(hexset[$urandom_range(0, 21)]);
    s.push_back(8'h0D);
    s.push_back(8'h0A);
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, s.size() - 1);
      while (s.size() > cut) void'(s.pop_back());
    end
    foreach (s[i]) send_byte(s[i]);
  endtask

  initial begin
    string     directed;
    int        mask_set[8];
    int        upper_set[8];
    int        quota;
    int        nnoise;
    mask_set  = '{7, 0, 1, 2, 4, 3, 5, 6};
    upper_set = '{0, 1, 0, 1, 1, 0, 1, 0};
    directed  = "$GLA*00\r\n$*ab$G*x\r$G$BD*\r\n";
    sb         = new();
    gap_pct    = 0;
    stall_pct  = 0;
    bytes_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_byte   <= 8'h00;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= 3'd0;
    pwdata    <= 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(nmea_trw_pkg::REG_SRC_MASK, 32'(mask_set[ph]));
      write_reg(nmea_trw_pkg::REG_HEX_UPPER, 32'(upper_set[ph]));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 71; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      quota = bytes_sent + 244;
      while (bytes_sent < quota) begin
        if ($urandom_range(0, 9) == 0) begin
          nnoise = $urandom_range(1, 4);
          for (int i = 0; i < nnoise; i++) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_sentence();
        end
      end
      wait_drained();
    end

    gap_pct   = 0;
    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS nmea_talker_rewrite_checksum_top");
    end else begin
      $display("FAIL nmea_talker_rewrite_checksum_top");
    end
    $finish;
  end

endmodule
